>>> rtl/sds_pkg.sv
`default_nettype none
package sds_pkg;

  localparam int unsigned INDEX_BITS_DEF = 32;
  localparam int unsigned OUT_INDEX_W    = 32;
  localparam int unsigned ADD_LAT        = 4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] POS_ZERO    = 64'h0;

  typedef struct packed {
    logic        opcode;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] segment_sum;
    logic [31:0] segment_index;
  } out_item_t;

  function automatic logic is_nan(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'h0);
  endfunction

  function automatic logic is_inf(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] == 52'h0);
  endfunction

endpackage
`default_nettype wire

>>> rtl/segmented_double_sum.sv
`default_nettype none
// segmented binary64 sum
// input channel: in_valid/in_stall with in_data (opcode, value); opcode add folds
//   value into the open segment, opcode close emits the segment and restarts at +0
// output channel: out_valid/out_stall with out_data (segment_sum, segment_index)
// front: a two-entry queue takes a transfer whenever it has room, so the input
//   is never held up by a stalled output until the queue fills
// back: one four-stage binary64 adder; each add depends on the previous sum, so
//   the back takes no new item until the adder has returned that sum
// a close lands in the output register when it is read from the queue; from input
//   transfer to result it passes the queue and the output register when no add is pending
// the back takes one close per cycle while the output is not stalled
// reset: sum goes to +0, index to 0, queue and output emptied
// when out_stall is high the result holds, further closes wait in the queue
module segmented_double_sum #(
  parameter int unsigned INDEX_BITS = sds_pkg::INDEX_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sds_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sds_pkg::out_item_t       out_data
);
  logic              q_full, q_empty, q_rd;
  sds_pkg::in_item_t q_data;

  // front part: queue of input transfers
  assign in_stall = q_full;

  sds_fifo #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_valid && !q_full), .wr_data(in_data), .full(q_full),
    .rd_en(q_rd), .rd_data(q_data), .empty(q_empty)
  );

  // back part: accumulator and output register
  sds_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_data(q_data), .q_rd(q_rd),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("stall without full queue");
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("back read empty queue");
`endif
endmodule
`default_nettype wire

>>> rtl/sds_fifo.sv
`default_nettype none
module sds_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire sds_pkg::in_item_t   wr_data,
  output logic                     full,
  input  wire logic                rd_en,
  output sds_pkg::in_item_t        rd_data,
  output logic                     empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sds_pkg::in_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd_en)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

>>> rtl/sds_fadd.sv
`default_nettype none
// binary64 adder, round to nearest even, four register stages
module sds_fadd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             out_vld,
  output logic [63:0]      res
);
  // stage 1: unpack, specials, swap, align
  logic        s1_vld_r;
  logic        s1_spec_r;
  logic [63:0] s1_spec_val_r;
  logic        s1_sa_r, s1_sb_r;
  logic [10:0] s1_e_r;
  logic [55:0] s1_ma_r, s1_mb_r;
  logic        s1_vld_nxt, s1_spec_nxt;
  logic [63:0] s1_spec_val_nxt;
  logic        s1_sa_nxt, s1_sb_nxt;
  logic [10:0] s1_e_nxt;
  logic [55:0] s1_ma_nxt, s1_mb_nxt;

  logic [63:0] big, lit;
  logic [10:0] eb, el, ebx, elx;
  logic [52:0] mbig, mlit;
  logic [11:0] dexp;
  logic [55:0] lit_ext, lit_sh;
  logic        sticky;
  logic [55:0] sticky_mask;

  always_comb begin
    s1_vld_nxt      = in_vld;
    s1_spec_nxt     = 1'b0;
    s1_spec_val_nxt = '0;
    if (sds_pkg::is_nan(a)) begin
      s1_spec_nxt = 1'b1; s1_spec_val_nxt = a | sds_pkg::QUIET_BIT;
    end else if (sds_pkg::is_nan(b)) begin
      s1_spec_nxt = 1'b1; s1_spec_val_nxt = b | sds_pkg::QUIET_BIT;
    end else if (sds_pkg::is_inf(a) && sds_pkg::is_inf(b)) begin
      s1_spec_nxt = 1'b1;
      s1_spec_val_nxt = (a[63] != b[63]) ? sds_pkg::DEFAULT_NAN : a;
    end else if (sds_pkg::is_inf(a)) begin
      s1_spec_nxt = 1'b1; s1_spec_val_nxt = a;
    end else if (sds_pkg::is_inf(b)) begin
      s1_spec_nxt = 1'b1; s1_spec_val_nxt = b;
    end
    if (a[62:0] >= b[62:0]) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    eb   = big[62:52];
    el   = lit[62:52];
    ebx  = (eb == '0) ? 11'd1 : eb;
    elx  = (el == '0) ? 11'd1 : el;
    mbig = {(eb != '0), big[51:0]};
    mlit = {(el != '0), lit[51:0]};
    dexp = {1'b0, ebx} - {1'b0, elx};
    lit_ext = {mlit, 3'b000};
    sticky_mask = '0;
    if (dexp >= 12'd56) begin
      lit_sh = '0;
      sticky = (mlit != '0);
    end else begin
      sticky_mask = ~(56'hFF_FFFF_FFFF_FFFF << dexp[5:0]);
      lit_sh = lit_ext >> dexp[5:0];
      sticky = ((lit_ext & sticky_mask) != '0);
    end
    s1_sa_nxt = big[63];
    s1_sb_nxt = lit[63];
    s1_e_nxt  = ebx;
    s1_ma_nxt = {mbig, 3'b000};
    s1_mb_nxt = {lit_sh[55:1], lit_sh[0] | sticky};
  end

  // stage 2: add or subtract
  logic        s2_vld_r, s2_spec_r;
  logic [63:0] s2_spec_val_r;
  logic        s2_s_r, s2_zero_r;
  logic [10:0] s2_e_r;
  logic [56:0] s2_m_r;
  logic        s2_zs;
  logic [56:0] s2_m_nxt;

  always_comb begin
    if (s1_sa_r == s1_sb_r) s2_m_nxt = {1'b0, s1_ma_r} + {1'b0, s1_mb_r};
    else                    s2_m_nxt = {1'b0, s1_ma_r} - {1'b0, s1_mb_r};
    // exact zero: sign is and of signs under round to nearest
    s2_zs = s1_sa_r & s1_sb_r;
  end

  // stage 3: normalise
  logic        s3_vld_r, s3_spec_r;
  logic [63:0] s3_spec_val_r;
  logic        s3_s_r, s3_zero_r;
  logic [12:0] s3_e_r;
  logic [55:0] s3_m_r;
  logic [5:0]  lz;
  logic [12:0] s3_e_nxt;
  logic [55:0] s3_m_nxt;
  logic [5:0]  sh;

  always_comb begin
    lz = 6'd56;
    sh = '0;
    for (int i = 0; i < 56; i++) begin
      if (s2_m_r[i]) lz = 6'(55 - i);
    end
    if (s2_m_r[56]) begin
      s3_m_nxt = {s2_m_r[56:2], s2_m_r[1] | s2_m_r[0]};
      s3_e_nxt = {2'b00, s2_e_r} + 13'd1;
    end else begin
      // stop at subnormal range
      if ({7'd0, lz} >= {2'b00, s2_e_r}) sh = 6'(s2_e_r - 11'd1);
      else sh = lz;
      s3_m_nxt = s2_m_r[55:0] << sh;
      s3_e_nxt = {2'b00, s2_e_r} - {7'd0, sh};
    end
  end

  // stage 4: round and pack
  logic        s4_vld_r;
  logic [63:0] s4_res_r, s4_res_nxt;
  logic        rup;
  logic [53:0] mr;
  logic [12:0] er;

  always_comb begin
    rup = s3_m_r[2] && (s3_m_r[1] || s3_m_r[0] || s3_m_r[3]);
    mr  = {1'b0, s3_m_r[55:3]} + {53'd0, rup};
    er  = s3_e_r;
    if (mr[53]) begin
      mr = mr >> 1;
      er = er + 13'd1;
    end
    if (s3_spec_r) begin
      s4_res_nxt = s3_spec_val_r;
    end else if (s3_zero_r) begin
      s4_res_nxt = {s3_s_r, 63'd0};
    end else if (er >= 13'd2047) begin
      s4_res_nxt = {s3_s_r, 11'h7FF, 52'd0};
    end else if (!mr[52]) begin
      s4_res_nxt = {s3_s_r, 11'd0, mr[51:0]};
    end else begin
      s4_res_nxt = {s3_s_r, er[10:0], mr[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    s1_spec_r     <= s1_spec_nxt;
    s1_spec_val_r <= s1_spec_val_nxt;
    s1_sa_r       <= s1_sa_nxt;
    s1_sb_r       <= s1_sb_nxt;
    s1_e_r        <= s1_e_nxt;
    s1_ma_r       <= s1_ma_nxt;
    s1_mb_r       <= s1_mb_nxt;
    s2_spec_r     <= s1_spec_r;
    s2_spec_val_r <= s1_spec_val_r;
    s2_e_r        <= s1_e_r;
    s2_m_r        <= s2_m_nxt;
    s2_zero_r     <= (s2_m_nxt == '0);
    s2_s_r        <= (s2_m_nxt == '0) ? s2_zs : s1_sa_r;
    s3_spec_r     <= s2_spec_r;
    s3_spec_val_r <= s2_spec_val_r;
    s3_s_r        <= s2_s_r;
    s3_zero_r     <= s2_zero_r;
    s3_e_r        <= s3_e_nxt;
    s3_m_r        <= s3_m_nxt;
    s4_res_r      <= s4_res_nxt;
  end

  assign out_vld = s4_vld_r;
  assign res     = s4_res_r;
endmodule
`default_nettype wire

>>> rtl/sds_back.sv
`default_nettype none
module sds_back #(
  parameter int unsigned INDEX_BITS = sds_pkg::INDEX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire sds_pkg::in_item_t  q_data,
  output logic                    q_rd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sds_pkg::out_item_t      out_data
);
  logic              busy_r, busy_nxt;
  logic [63:0]       sum_r, sum_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic              ovld_r, ovld_nxt;
  sds_pkg::out_item_t odata_r, odata_nxt;
  logic              add_go, add_done;
  logic [63:0]       add_res;
  logic              out_free;

  assign out_free = !ovld_r || !out_stall;
  // an add or a close waits for the adder; a close also waits for a free output slot
  always_comb begin
    q_rd   = 1'b0;
    add_go = 1'b0;
    if (!q_empty && !busy_r) begin
      if (q_data.opcode == sds_pkg::OP_ADD) begin
        q_rd = 1'b1; add_go = 1'b1;
      end else if (out_free) begin
        q_rd = 1'b1;
      end
    end
  end

  sds_fadd u_fadd (
    .clk(clk), .rst_n(rst_n), .in_vld(add_go), .a(sum_r), .b(q_data.value),
    .out_vld(add_done), .res(add_res)
  );

  always_comb begin
    busy_nxt  = busy_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && out_stall;
    odata_nxt = odata_r;
    if (add_go) busy_nxt = 1'b1;
    if (add_done) begin
      busy_nxt = 1'b0;
      sum_nxt  = add_res;
    end
    if (q_rd && q_data.opcode == sds_pkg::OP_CLOSE) begin
      ovld_nxt  = 1'b1;
      odata_nxt.segment_sum = sum_r;
      odata_nxt.segment_index = 32'(cnt_r);
      sum_nxt   = sds_pkg::POS_ZERO;
      cnt_nxt   = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sum_r  <= sds_pkg::POS_ZERO;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

`ifndef SYNTHESIS
  a_no_issue_busy: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !q_rd)
    else $error("queue read during add");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) add_done |-> busy_r)
    else $error("adder result without pending add");
  a_add_lat: assert property (@(posedge clk) disable iff (!rst_n)
    add_go |-> ##(sds_pkg::ADD_LAT) add_done)
    else $error("adder latency broken");
`endif
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned RAND_ITEMS = 1220;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  sds_pkg::in_item_t  in_data = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  sds_pkg::out_item_t out_data;

  // items waiting to be offered, and closed segments still to come out
  sds_pkg::in_item_t  pending_items[$];
  sds_pkg::out_item_t segment_results[$];

  // own copy of the block state
  logic [63:0] open_sum = sds_pkg::POS_ZERO;
  logic [31:0] segment_ord = '0;

  int   total_items = 0;
  int   offered = 0;
  int   errors = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic in_took = 1'b0;

  segmented_double_sum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // binary64 add, left operand is the running sum
  function automatic logic [63:0] fp_sum(input logic [63:0] acc, input logic [63:0] val);
    logic acc_nan, val_nan, acc_inf, val_inf;
    acc_nan = (&acc[62:52]) && (|acc[51:0]);
    val_nan = (&val[62:52]) && (|val[51:0]);
    acc_inf = (&acc[62:52]) && !(|acc[51:0]);
    val_inf = (&val[62:52]) && !(|val[51:0]);
    // nan operands are quietened with payload and sign kept, running sum first
    if (acc_nan) return acc | sds_pkg::QUIET_BIT;
    if (val_nan) return val | sds_pkg::QUIET_BIT;
    // opposite infinities give the default nan
    if (acc_inf && val_inf && (acc[63] != val[63])) return sds_pkg::DEFAULT_NAN;
    return $realtobits($bitstoreal(acc) + $bitstoreal(val));
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 11))
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'h7FF0_0000_0000_0000;                          // infinity
      4:       v = {1'b0, 11'h7FF, 1'b0, 19'h0, $urandom} | 64'h1;   // signalling nan
      5:       v = {1'b0, 11'h7FF, 1'b1, 19'h0, $urandom};           // quiet nan
      6:       v = {12'h0, 20'h0, $urandom};                         // subnormal
      7:       v = 64'h7FEF_FFFF_FFFF_FFFF;                          // largest finite
      8:       v = sds_pkg::POS_ZERO;
      default: v = $realtobits(real'($urandom_range(0, 1000)) / 8.0);
    endcase
    if ($urandom_range(0, 1)) v[63] = ~v[63];
    return v;
  endfunction

  function automatic sds_pkg::in_item_t mk(input logic op, input logic [63:0] v);
    sds_pkg::in_item_t it;
    it.opcode = op;
    it.value  = v;
    return it;
  endfunction

  // stimulus and end of run
  initial begin
    int seg_len;
    // directed: empty segment, signed zeros, overflow, opposite infinities
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h8000_0000_0000_0000));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h8000_0000_0000_0000));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h8000_0000_0000_0000));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h7FF0_0000_0000_0000));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'hFFF0_0000_0000_0000));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    // signalling nan in the value, then a nan already in the sum wins
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'hFFF0_0000_0000_0001));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h7FF4_0000_0000_1234));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'hFFF0_0000_0000_0055));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    // subnormals and an all-ones pattern
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h0000_0000_0000_0001));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'h000F_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(sds_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(sds_pkg::OP_CLOSE, '0));
    // random: mostly segments of a few adds, some long, some empty
    while (pending_items.size() < RAND_ITEMS + 21) begin
      seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      repeat (seg_len) pending_items.push_back(mk(sds_pkg::OP_ADD, pick_value()));
      pending_items.push_back(mk(sds_pkg::OP_CLOSE, {$urandom, $urandom}));
    end
    total_items = pending_items.size();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || segment_results.size() != 0);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // driver: offers the next item once the current one has transferred
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (offered < total_items / 3) ? 14 : (offered < 2 * total_items / 3) ? 54 : 0;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        offered  <= offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the front queue fills
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (offered < total_items / 3) ? 54 : (offered < 2 * total_items / 3) ? 14 : 0;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && offered >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: check results first, then fold in the accepted input transfer
  always @(posedge clk) begin
    sds_pkg::out_item_t exp_item;
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (segment_results.size() == 0) begin
          $error("result with no segment closed: sum %h index %0d",
                 out_data.segment_sum, out_data.segment_index);
          errors++;
        end else begin
          exp_item = segment_results.pop_front();
          if (out_data.segment_sum !== exp_item.segment_sum) begin
            $error("segment_sum expected %h actual %h",
                   exp_item.segment_sum, out_data.segment_sum);
            errors++;
          end
          if (out_data.segment_index !== exp_item.segment_index) begin
            $error("segment_index expected %0d actual %0d",
                   exp_item.segment_index, out_data.segment_index);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == sds_pkg::OP_ADD) begin
          open_sum = fp_sum(open_sum, in_data.value);
        end else begin
          exp_item.segment_sum   = open_sum;
          exp_item.segment_index = segment_ord;
          segment_results.push_back(exp_item);
          open_sum    = sds_pkg::POS_ZERO;
          segment_ord = segment_ord + 1;
        end
      end
    end
  end

endmodule
